FILE: src/first_fit_free_list_allocator_assert.svh
// assertion macros for the first-fit free-list allocator
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define FFA_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffa assertion failed");

// next-cycle implication, disabled while reset is asserted
`define FFA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffa assertion failed");

`endif

FILE: src/ffa_pkg.sv
// shared types and constants of the first-fit allocator
`default_nettype none

package ffa_pkg;

  localparam int unsigned REQ_BYTES_W = 16;
  localparam int unsigned UNIT_W      = 12;
  localparam int unsigned UNITS_W     = 13;
  // units needed by one request, header included
  localparam int unsigned NEED_W      = 17;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic link_we;
    logic size_we;
  } mem_we_t;

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_DIV     = 20'h00002,
    S_INIT    = 20'h00004,
    S_WALK0   = 20'h00008,
    S_WALK1   = 20'h00010,
    S_WALK2   = 20'h00020,
    S_WALK3   = 20'h00040,
    S_ALLOC_X = 20'h00080,
    S_SPLIT1  = 20'h00100,
    S_SPLIT2  = 20'h00200,
    S_GROW    = 20'h00400,
    S_INS_RD  = 20'h00800,
    S_INS_CHK = 20'h01000,
    S_INS_B1  = 20'h02000,
    S_INS_B2  = 20'h04000,
    S_INS_B3  = 20'h08000,
    S_INS_B4  = 20'h10000,
    S_INS_B5  = 20'h20000,
    S_INS_B6  = 20'h40000,
    S_FIN     = 20'h80000
  } state_e;

endpackage

`default_nettype wire

FILE: src/ffa_req_if.sv
// request channel of the allocator
`default_nettype none

interface ffa_req_if import ffa_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [REQ_BYTES_W-1:0] request_bytes;
  logic [UNIT_W-1:0]      release_unit;

  modport source (output valid, action, request_bytes, release_unit, input ready);
  modport sink   (input valid, action, request_bytes, release_unit, output ready);
endinterface

`default_nettype wire

FILE: src/ffa_rsp_if.sv
// response channel of the allocator
`default_nettype none

interface ffa_rsp_if import ffa_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [UNIT_W-1:0]  granted_unit;
  logic [UNITS_W-1:0] granted_units;
  logic               ok;

  modport source (output valid, granted_unit, granted_units, ok, input ready);
  modport sink   (input valid, granted_unit, granted_units, ok, output ready);
endinterface

`default_nettype wire

FILE: src/ffa_div.sv
// constant divider by reciprocal multiplication, quotient registered in the cycle after start
`default_nettype none

module ffa_div #(
  parameter int unsigned DIVISOR = 16,
  parameter int unsigned W       = 17
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  output logic      [W-1:0] quot_o,
  output logic              done_o
);

  // x / DIVISOR == (x * RECIP) >> SH for every x below 2**W
  localparam int unsigned     SH    = W + $clog2(DIVISOR);
  localparam int unsigned     PW    = SH + W;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [PW-1:0] prod_q, prod_d;
  logic          done_q;

  assign prod_d = PW'(dividend_i) * PW'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= prod_d;
    end
  end

  assign quot_o = prod_q[SH +: W];
  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: src/ffa_ram.sv
// link and size memories, one shared address, registered read
`default_nettype none

module ffa_ram import ffa_pkg::*; #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned SW    = 13
) (
  input  wire logic          clk_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire mem_we_t       we_i,
  input  wire logic [AW-1:0] link_i,
  input  wire logic [SW-1:0] size_i,
  output logic      [AW-1:0] link_o,
  output logic      [SW-1:0] size_o
);

  logic [AW-1:0] link_mem [DEPTH];
  logic [SW-1:0] size_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i.link_we) begin
      link_mem[addr_i] <= link_i;
    end
    link_o <= link_mem[addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i.size_we) begin
      size_mem[addr_i] <= size_i;
    end
    size_o <= size_mem[addr_i];
  end

endmodule

`default_nettype wire

FILE: src/first_fit_free_list_allocator.sv
// top level: first-fit circular free-list allocator with its sequencer
//
//   channel | dir | payload                                    | accepted when
//   req_i   | in  | action, request_bytes, release_unit        | valid && ready
//   rsp_o   | out | granted_unit, granted_units, ok            | valid && ready
//
// one item at a time; ready is high only while the sequencer is idle
// allocate: unit conversion, start of the walk (sentinel set up the first time),
//   a visit per free block, an exact-fit or split grant, then the result hand-over
// each growth writes a new block at the heap top, inserts it and resumes the walk
// free: insert walk, merges above and below; an ignored free goes to hand-over
// reset zeroes rover, sets heap top to 1, clears list state; a stalled result holds
//   the sequencer in its last state until the output register frees up
`default_nettype none

module first_fit_free_list_allocator import ffa_pkg::*; #(
  parameter int unsigned ARENA_UNITS  = 4096,
  parameter int unsigned GROW_UNITS   = 1024,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ffa_req_if.sink   req_i,
  ffa_rsp_if.source rsp_o
);

  localparam int unsigned AW    = $clog2(ARENA_UNITS);
  localparam int unsigned SW    = AW + 1;
  localparam int unsigned XW    = ((SW > NEED_W) ? SW : NEED_W) + 1;
  localparam int unsigned LIMIT = 4 * ARENA_UNITS + 8;
  localparam int unsigned CW    = AW + 3;

  localparam logic [XW-1:0] ARENA_X = XW'(ARENA_UNITS);
  localparam logic [XW-1:0] GROW_X  = XW'(GROW_UNITS);
  localparam logic [CW-1:0] LIMIT_C = CW'(LIMIT);

  state_e state_q, state_d;

  // item context
  logic [AW-1:0]     bp_q, bp_d;        // header of the block being inserted
  logic [NEED_W-1:0] n_q, n_d;          // units requested, header included
  logic [AW-1:0]     prevp_q, prevp_d;
  logic [AW-1:0]     p_q, p_d;
  logic [AW-1:0]     nxt_q, nxt_d;
  logic [SW-1:0]     sp_q, sp_d;        // size of the block under the walk
  logic [AW-1:0]     lp_q, lp_d;        // its link
  logic [SW-1:0]     sb_q, sb_d;        // size of inserted block after upper merge
  logic [AW-1:0]     lb_q, lb_d;        // its link after upper merge
  logic [CW-1:0]     wsteps_q, wsteps_d;
  logic [CW-1:0]     isteps_q, isteps_d;
  logic              grow_q, grow_d;    // insert comes from an arena growth

  // allocator state
  logic [AW-1:0] rover_q, rover_d;
  logic [SW-1:0] heap_top_q, heap_top_d;
  logic          started_q, started_d;

  // result
  logic [UNIT_W-1:0]  res_unit_q, res_unit_d;
  logic [UNITS_W-1:0] res_units_q, res_units_d;
  logic               res_ok_q, res_ok_d;
  logic               out_valid_q, out_valid_d;
  logic [UNIT_W-1:0]  out_unit_q, out_unit_d;
  logic [UNITS_W-1:0] out_units_q, out_units_d;
  logic               out_ok_q, out_ok_d;

  // memory port
  logic [AW-1:0] mem_addr;
  mem_we_t       mem_we;
  logic [AW-1:0] mem_wlink;
  logic [SW-1:0] mem_wsize;
  logic [AW-1:0] mem_rlink;
  logic [SW-1:0] mem_rsize;

  // unit conversion
  logic              div_start;
  logic              div_done;
  logic [NEED_W-1:0] div_quot;
  logic [NEED_W-1:0] div_dividend;

  assign div_dividend = NEED_W'(req_i.request_bytes) + NEED_W'(HEADER_BYTES - 1);

  ffa_div #(
    .DIVISOR (HEADER_BYTES),
    .W       (NEED_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  ffa_ram #(
    .DEPTH (ARENA_UNITS),
    .AW    (AW),
    .SW    (SW)
  ) u_ram (
    .clk_i  (clk_i),
    .addr_i (mem_addr),
    .we_i   (mem_we),
    .link_i (mem_wlink),
    .size_i (mem_wsize),
    .link_o (mem_rlink),
    .size_o (mem_rsize)
  );

  // scratch values of the sequencer
  logic [UNIT_W-1:0] rel_hdr;
  logic [XW-1:0]     nu;
  logic [XW-1:0]     split_sum;
  logic [AW-1:0]     split_at;
  logic              ins_here;

  assign rel_hdr = req_i.release_unit - 1'b1;
  assign nu      = (XW'(n_q) < GROW_X) ? GROW_X : XW'(n_q);

  // tail of a split block, wrapped into the arena
  always_comb begin
    split_sum = XW'(p_q) + XW'(sp_q - SW'(n_q));
    if (split_sum >= ARENA_X) begin
      split_sum = split_sum - ARENA_X;
    end
    split_at = AW'(split_sum);
  end

  // bp lies between p and the next block, or past the wrap of the list
  assign ins_here = (bp_q > p_q && bp_q < mem_rlink) ||
                    (p_q >= mem_rlink && (bp_q > p_q || bp_q < mem_rlink));

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    bp_d        = bp_q;
    n_d         = n_q;
    prevp_d     = prevp_q;
    p_d         = p_q;
    nxt_d       = nxt_q;
    sp_d        = sp_q;
    lp_d        = lp_q;
    sb_d        = sb_q;
    lb_d        = lb_q;
    wsteps_d    = wsteps_q;
    isteps_d    = isteps_q;
    grow_d      = grow_q;
    rover_d     = rover_q;
    heap_top_d  = heap_top_q;
    started_d   = started_q;
    res_unit_d  = res_unit_q;
    res_units_d = res_units_q;
    res_ok_d    = res_ok_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_unit_d  = out_unit_q;
    out_units_d = out_units_q;
    out_ok_d    = out_ok_q;
    div_start   = 1'b0;
    mem_addr    = p_q;
    mem_we      = '0;
    mem_wlink   = '0;
    mem_wsize   = '0;

    unique case (state_q)
      S_IDLE: begin
        res_unit_d  = '0;
        res_units_d = '0;
        res_ok_d    = 1'b0;
        if (req_i.valid) begin
          if (req_i.action == ACT_FREE) begin
            if (req_i.release_unit == '0 || rel_hdr == '0 ||
                32'(rel_hdr) >= 32'(heap_top_q)) begin
              state_d = S_FIN;  // outside the grown arena
            end else begin
              bp_d     = AW'(rel_hdr);
              p_d      = rover_q;
              isteps_d = '0;
              grow_d   = 1'b0;
              state_d  = S_INS_RD;
            end
          end else begin
            div_start = 1'b1;
            wsteps_d  = '0;
            state_d   = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          n_d     = div_quot + 1'b1;
          state_d = started_q ? S_WALK0 : S_INIT;
        end
      end

      S_INIT: begin
        // sentinel at unit zero links to itself with size zero
        mem_addr  = '0;
        mem_we    = '{link_we: 1'b1, size_we: 1'b1};
        rover_d   = '0;
        started_d = 1'b1;
        state_d   = S_WALK0;
      end

      S_WALK0: begin
        if (XW'(n_q) > ARENA_X) begin
          state_d = S_FIN;  // never fits
        end else begin
          mem_addr = rover_q;
          prevp_d  = rover_q;
          state_d  = S_WALK1;
        end
      end

      S_WALK1: begin
        p_d     = mem_rlink;
        state_d = S_WALK2;
      end

      S_WALK2: begin
        mem_addr = p_q;
        state_d  = S_WALK3;
      end

      S_WALK3: begin
        sp_d = mem_rsize;
        lp_d = mem_rlink;
        if (XW'(mem_rsize) >= XW'(n_q)) begin
          state_d = (XW'(mem_rsize) == XW'(n_q)) ? S_ALLOC_X : S_SPLIT1;
        end else if (p_q == rover_q) begin
          state_d = S_GROW;  // a full lap without a fit
        end else if (wsteps_q + 1'b1 > LIMIT_C) begin
          state_d = S_FIN;
        end else begin
          prevp_d  = p_q;
          p_d      = mem_rlink;
          wsteps_d = wsteps_q + 1'b1;
          state_d  = S_WALK2;
        end
      end

      S_ALLOC_X: begin
        // exact fit: unlink the whole block
        mem_addr    = prevp_q;
        mem_we      = '{link_we: 1'b1, size_we: 1'b0};
        mem_wlink   = lp_q;
        rover_d     = prevp_q;
        res_unit_d  = UNIT_W'(SW'(p_q) + 1'b1);
        res_units_d = UNITS_W'(n_q);
        res_ok_d    = 1'b1;
        state_d     = S_FIN;
      end

      S_SPLIT1: begin
        // shrink the free block, its tail is handed out
        mem_addr  = p_q;
        mem_we    = '{link_we: 1'b0, size_we: 1'b1};
        mem_wsize = sp_q - SW'(n_q);
        rover_d   = prevp_q;
        state_d   = S_SPLIT2;
      end

      S_SPLIT2: begin
        mem_addr    = split_at;
        mem_we      = '{link_we: 1'b0, size_we: 1'b1};
        mem_wsize   = SW'(n_q);
        res_unit_d  = UNIT_W'(SW'(split_at) + 1'b1);
        res_units_d = UNITS_W'(n_q);
        res_ok_d    = 1'b1;
        state_d     = S_FIN;
      end

      S_GROW: begin
        if (XW'(heap_top_q) + nu > ARENA_X) begin
          state_d = S_FIN;  // arena exhausted
        end else begin
          mem_addr   = AW'(heap_top_q);
          mem_we     = '{link_we: 1'b0, size_we: 1'b1};
          mem_wsize  = SW'(nu);
          bp_d       = AW'(heap_top_q);
          heap_top_d = SW'(XW'(heap_top_q) + nu);
          p_d        = rover_q;
          isteps_d   = '0;
          grow_d     = 1'b1;
          state_d    = S_INS_RD;
        end
      end

      S_INS_RD: begin
        mem_addr = p_q;
        state_d  = S_INS_CHK;
      end

      S_INS_CHK: begin
        if (ins_here) begin
          nxt_d   = mem_rlink;
          state_d = S_INS_B1;
        end else if (isteps_q + 1'b1 > LIMIT_C) begin
          state_d = S_FIN;  // runaway walk, nothing written
        end else begin
          p_d      = mem_rlink;
          isteps_d = isteps_q + 1'b1;
          state_d  = S_INS_RD;
        end
      end

      S_INS_B1: begin
        mem_addr = bp_q;
        state_d  = S_INS_B2;
      end

      S_INS_B2: begin
        sb_d     = mem_rsize;
        mem_addr = nxt_q;
        state_d  = S_INS_B3;
      end

      S_INS_B3: begin
        // merge with the free block above
        if (XW'(bp_q) + XW'(sb_q) == XW'(nxt_q)) begin
          sb_d = sb_q + mem_rsize;
          lb_d = mem_rlink;
        end else begin
          lb_d = nxt_q;
        end
        state_d = S_INS_B4;
      end

      S_INS_B4: begin
        mem_addr  = bp_q;
        mem_we    = '{link_we: 1'b1, size_we: 1'b1};
        mem_wlink = lb_q;
        mem_wsize = sb_q;
        state_d   = S_INS_B5;
      end

      S_INS_B5: begin
        mem_addr = p_q;
        state_d  = S_INS_B6;
      end

      S_INS_B6: begin
        // merge with the free block below
        mem_addr = p_q;
        if (XW'(p_q) + XW'(mem_rsize) == XW'(bp_q)) begin
          mem_we    = '{link_we: 1'b1, size_we: 1'b1};
          mem_wsize = mem_rsize + sb_q;
          mem_wlink = lb_q;
        end else begin
          mem_we    = '{link_we: 1'b1, size_we: 1'b0};
          mem_wlink = bp_q;
        end
        rover_d = p_q;
        if (grow_q) begin
          // walk resumes from the new rover
          if (wsteps_q + 1'b1 > LIMIT_C) begin
            state_d = S_FIN;
          end else begin
            wsteps_d = wsteps_q + 1'b1;
            state_d  = S_WALK0;
          end
        end else begin
          res_ok_d = 1'b1;
          state_d  = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_unit_d  = res_unit_q;
          out_units_d = res_units_q;
          out_ok_d    = res_ok_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rover_q     <= '0;
      heap_top_q  <= SW'(1);
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rover_q     <= rover_d;
      heap_top_q  <= heap_top_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q        <= bp_d;
    n_q         <= n_d;
    prevp_q     <= prevp_d;
    p_q         <= p_d;
    nxt_q       <= nxt_d;
    sp_q        <= sp_d;
    lp_q        <= lp_d;
    sb_q        <= sb_d;
    lb_q        <= lb_d;
    wsteps_q    <= wsteps_d;
    isteps_q    <= isteps_d;
    grow_q      <= grow_d;
    res_unit_q  <= res_unit_d;
    res_units_q <= res_units_d;
    res_ok_q    <= res_ok_d;
    out_unit_q  <= out_unit_d;
    out_units_q <= out_units_d;
    out_ok_q    <= out_ok_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.granted_unit  = out_unit_q;
  assign rsp_o.granted_units = out_units_q;
  assign rsp_o.ok            = out_ok_q;

endmodule

`default_nettype wire

FILE: src/ffa_checker.sv
// port-level checks of the allocator, bound to the top level
`default_nettype none

`include "first_fit_free_list_allocator_assert.svh"

module ffa_checker import ffa_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               req_valid_i,
  input wire logic               req_ready_i,
  input wire logic               rsp_valid_i,
  input wire logic               rsp_ready_i,
  input wire logic [UNIT_W-1:0]  rsp_unit_i,
  input wire logic [UNITS_W-1:0] rsp_units_i,
  input wire logic               rsp_ok_i
);

  logic req_acc;
  logic rsp_stall;

  assign req_acc   = req_valid_i && req_ready_i;
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;

  // a stalled result holds
  `FFA_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall,
    rsp_valid_i && $stable(rsp_unit_i) && $stable(rsp_units_i) && $stable(rsp_ok_i))

  // busy right after taking an item
  `FFA_ASSERT_NEXT(a_busy_after_acc, clk_i, rst_ni, req_acc, !req_ready_i)

  // a failed item grants nothing
  `FFA_ASSERT_NOW(a_fail_empty, clk_i, rst_ni, rsp_valid_i && !rsp_ok_i,
    rsp_unit_i == '0 && rsp_units_i == '0)

  // a granted size always comes with success
  `FFA_ASSERT_NOW(a_size_ok, clk_i, rst_ni, rsp_valid_i && rsp_units_i != '0, rsp_ok_i)

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_unit_i  (rsp_o.granted_unit),
  .rsp_units_i (rsp_o.granted_units),
  .rsp_ok_i    (rsp_o.ok)
);

`default_nettype wire
